// ===== hw/rtl/brc_pkg.sv =====
// Package for the brush image recolor core: shared types and constants.
// Used by brc_analyze, brc_recolor and brush_image_recolor_core; no dependencies.
`default_nettype none

package brc_pkg;

  // Request types carried with each item
  localparam logic [1:0] REQ_RESTART = 2'd0;
  localparam logic [1:0] REQ_ANALYZE = 2'd1;
  localparam logic [1:0] REQ_RECOLOR = 2'd2;

  // Pixel formats (any other code is treated as RGBA)
  localparam logic [1:0] FMT_RGBA    = 2'd0;
  localparam logic [1:0] FMT_GRAY    = 2'd1;
  localparam logic [1:0] FMT_INDEXED = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_PIXEL_FORMAT = 3'd0;
  localparam logic [2:0] CFG_USE_MAIN     = 3'd1;
  localparam logic [2:0] CFG_MAIN_COLOR   = 3'd2;
  localparam logic [2:0] CFG_USE_BG       = 3'd3;
  localparam logic [2:0] CFG_BG_COLOR     = 3'd4;
  localparam logic [2:0] CFG_MASK_INDEX   = 3'd5;

  // Pixel masks per format
  localparam logic [31:0] MASK_FULL  = 32'hFFFF_FFFF;
  localparam logic [31:0] MASK_GRAY  = 32'h0000_FFFF;
  localparam logic [31:0] MASK_INDEX = 32'h0000_00FF;
  localparam logic [31:0] ALPHA_RGBA = 32'hFF00_0000;
  localparam logic [31:0] ALPHA_GRAY = 32'h0000_FF00;
  localparam logic [31:0] COLOR_RGBA = 32'h00FF_FFFF;
  localparam logic [31:0] COLOR_LOW8 = 32'h0000_00FF;

  // Configuration register set
  typedef struct packed {
    logic [1:0]  pixel_format;
    logic        use_main;
    logic [31:0] main_color;
    logic        use_bg;
    logic [31:0] bg_color;
    logic [7:0]  mask_index;
  } brc_cfg_t;

  // Analysis state handed from the analyser to the recolour logic
  typedef struct packed {
    logic        has_transparent;
    logic        seen_opaque;
    logic [31:0] src_main;
    logic [31:0] src_back;
  } brc_state_t;

  // Cut a raw pixel to the width of the configured format
  function automatic logic [31:0] fmt_mask(input logic [1:0] fmt);
    logic [31:0] m;
    unique case (fmt)
      FMT_GRAY:    m = MASK_GRAY;
      FMT_INDEXED: m = MASK_INDEX;
      default:     m = MASK_FULL;
    endcase
    return m;
  endfunction

  // Alpha bits of the format (indexed uses the RGBA mask but never reads it)
  function automatic logic [31:0] fmt_alpha(input logic [1:0] fmt);
    return (fmt == FMT_GRAY) ? ALPHA_GRAY : ALPHA_RGBA;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/brc_analyze.sv =====
// Analysis state of the brush image recolor core: transparency flag,
// background and main source colours. Depends on brc_pkg.
`default_nettype none

module brc_analyze import brc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        upd,        // staged item leaves the input register
  input  wire logic [1:0]  req,
  input  wire logic [31:0] pixel,      // already cut to the format width
  input  wire brc_cfg_t    cfg,
  output brc_state_t       state
);

  brc_state_t state_next;
  logic       transparent;

  // Transparency test per format
  always_comb begin
    if (cfg.pixel_format == FMT_INDEXED) begin
      transparent = (pixel == {24'd0, cfg.mask_index});
    end else begin
      transparent = ((pixel & fmt_alpha(cfg.pixel_format)) != fmt_alpha(cfg.pixel_format));
    end
  end

  // Next state for restart and analyse items
  always_comb begin
    state_next = state;
    if (req == REQ_RESTART) begin
      state_next = '0;
    end else if (req == REQ_ANALYZE) begin
      priority if (transparent) begin
        state_next.has_transparent = 1'b1;
      end else if (!state.seen_opaque) begin
        state_next.src_main    = pixel;
        state_next.src_back    = pixel;
        state_next.seen_opaque = 1'b1;
      end else if (pixel != state.src_back && state.src_main == state.src_back) begin
        state_next.src_main = pixel;
      end else begin
        // opaque pixel that leaves both source colours as they are
        state_next = state;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (upd) begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/brc_recolor.sv =====
// Recolour logic of the brush image recolor core: picks the new colour of one
// pixel from the analysis state and the configuration. Depends on brc_pkg.
`default_nettype none

module brc_recolor import brc_pkg::*; (
  input  wire logic [31:0] pixel,      // already cut to the format width
  input  wire brc_cfg_t    cfg,
  input  wire brc_state_t  state,
  output logic [31:0]      result
);

  logic        indexed;
  logic [31:0] keep;
  logic [31:0] cmask;
  logic [31:0] new_main;
  logic [31:0] new_back;
  logic [31:0] sentinel;
  logic [31:0] back;
  logic [31:0] mainc;
  logic [31:0] pick;

  // Replacement colours keep the pixel's own alpha
  always_comb begin
    indexed  = (cfg.pixel_format == FMT_INDEXED);
    keep     = indexed ? 32'd0 : (pixel & fmt_alpha(cfg.pixel_format));
    cmask    = (indexed || cfg.pixel_format == FMT_GRAY) ? COLOR_LOW8 : COLOR_RGBA;
    new_main = keep | (cfg.main_color & cmask);
    new_back = keep | (cfg.bg_color & cmask);
    sentinel = indexed ? {24'd0, cfg.mask_index} : 32'd0;
    back     = state.seen_opaque ? state.src_back : sentinel;
    mainc    = state.seen_opaque ? state.src_main : sentinel;
  end

  // Colour choice; transparent images recolour every non-mask pixel when main or background recolouring is enabled
  always_comb begin
    if (state.has_transparent) begin
      priority if (indexed && pixel == {24'd0, cfg.mask_index}) begin
        pick = pixel;
      end else if (cfg.use_main) begin
        pick = new_main;
      end else if (cfg.use_bg) begin
        pick = new_back;
      end else begin
        pick = pixel;
      end
    end else begin
      priority if (cfg.use_main && (pixel != back || mainc == back)) begin
        pick = new_main;
      end else if (cfg.use_bg && pixel == back) begin
        pick = new_back;
      end else begin
        pick = pixel;
      end
    end
    result = pick & fmt_mask(cfg.pixel_format);
  end

endmodule

`default_nettype wire

// ===== hw/rtl/brush_image_recolor_core.sv =====
// Top level of the brush image recolor core: configuration registers,
// input register and result register. Depends on brc_pkg, brc_analyze, brc_recolor.
`default_nettype none

// One item is accepted every cycle while in_stall is low. An item sits in the
// input register until it moves on; there the analysis state is updated or the
// pixel is recoloured from the state left by all earlier items. A recolour
// result is loaded into the result register as its item moves on and is held
// there while out_stall is high. Restart, analyse and unused request codes
// give no result. in_stall rises only while the staged item is a recolour
// item and the result register holds a result that is itself stalled.
// Configuration should be written only while no item is in flight.
module brush_image_recolor_core import brc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration write port
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  req_type,
  input  wire logic [31:0] pixel_in,
  // output channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      pixel_out
);

  brc_cfg_t    cfg;
  brc_state_t  state;

  logic        s1_valid;
  logic [1:0]  s1_req;
  logic [31:0] s1_pixel;
  logic [31:0] s1_pixel_cut;
  logic        s1_recolor;
  logic        s1_adv;
  logic        in_take;
  logic [31:0] recolor_result;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_PIXEL_FORMAT: cfg.pixel_format <= cfg_data[1:0];
        CFG_USE_MAIN:     cfg.use_main     <= cfg_data[0];
        CFG_MAIN_COLOR:   cfg.main_color   <= cfg_data;
        CFG_USE_BG:       cfg.use_bg       <= cfg_data[0];
        CFG_BG_COLOR:     cfg.bg_color     <= cfg_data;
        CFG_MASK_INDEX:   cfg.mask_index   <= cfg_data[7:0];
        default:          ;
      endcase
    end
  end

  // Handshake: the staged item moves on unless its result has nowhere to go
  always_comb begin
    s1_recolor = (s1_req == REQ_RECOLOR);
    s1_adv     = s1_valid && (!s1_recolor || !out_valid || !out_stall);
    in_stall   = s1_valid && !s1_adv;
    in_take    = in_valid && !in_stall;
    s1_pixel_cut = s1_pixel & fmt_mask(cfg.pixel_format);
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take || s1_adv) begin
      s1_valid <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_req   <= req_type;
      s1_pixel <= pixel_in;
    end
  end

  brc_analyze u_analyze (
    .clk   (clk),
    .rst   (rst),
    .upd   (s1_adv),
    .req   (s1_req),
    .pixel (s1_pixel_cut),
    .cfg   (cfg),
    .state (state)
  );

  brc_recolor u_recolor (
    .pixel  (s1_pixel_cut),
    .cfg    (cfg),
    .state  (state),
    .result (recolor_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_recolor) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_recolor) begin
      pixel_out <= recolor_result;
    end
  end

endmodule

`default_nettype wire
